>>> design/remote_section_switch_handler_macros.svh
// Assertion macros shared by the remote section switch handler modules.
`ifndef REMOTE_SECTION_SWITCH_HANDLER_MACROS_SVH
`define REMOTE_SECTION_SWITCH_HANDLER_MACROS_SVH
`ifndef ASSERT_OFF
`define RSSH_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);
`define RSSH_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`else
`define RSSH_ASSERT(lbl, ck, rn, prop, msg)
`define RSSH_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)
`endif
`endif

>>> design/rssh_pkg.sv
// Shared constants, codes and types of the remote section switch handler.
package rssh_pkg;
  localparam int MAX_SECTIONS_DEF = 64;
  localparam int NUM_ZONES_DEF    = 8;
  localparam int MASK_W           = 64;
  localparam int ZONE_ENTRY_W     = 7;
  localparam int ZONE_TABLE_W     = 56;
  localparam int CFG_DATA_W       = 56;
  localparam int CFG_INDEX_W      = 2;
  localparam int SECTION_COUNT_W  = 5;
  localparam int SWITCH_W         = 8;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_FEATURE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ZONES      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_COUNT      = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ZONE_TABLE = 2'd3;

  typedef logic [1:0] sec_state_t;
  localparam sec_state_t ST_OFF  = 2'd0;
  localparam sec_state_t ST_AUTO = 2'd1;
  localparam sec_state_t ST_ON   = 2'd2;

  typedef struct packed {
    logic              master_auto;
    logic [MASK_W-1:0] on_hit;
    logic [MASK_W-1:0] fall_hit;
    logic [MASK_W-1:0] off_hit;
  } cmd_t;
endpackage

>>> design/rssh_front.sv
// Front end: configuration, master mode, previous switch bytes and per-section hit masks.
`include "remote_section_switch_handler_macros.svh"
module rssh_front #(
  parameter int MAX_SECTIONS = rssh_pkg::MAX_SECTIONS_DEF,
  parameter int NUM_ZONES    = rssh_pkg::NUM_ZONES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                in_job_active,
  input  logic [rssh_pkg::SWITCH_W-1:0]       in_main_switch,
  input  logic [rssh_pkg::SWITCH_W-1:0]       in_on_low,
  input  logic [rssh_pkg::SWITCH_W-1:0]       in_on_high,
  input  logic [rssh_pkg::SWITCH_W-1:0]       in_off_low,
  input  logic [rssh_pkg::SWITCH_W-1:0]       in_off_high,
  input  logic                                cfg_we,
  input  logic [rssh_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rssh_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic                                push,
  output rssh_pkg::cmd_t                      cmd
);
  logic                                   feat_r, feat_nxt;
  logic                                   zones_r, zones_nxt;
  logic [rssh_pkg::SECTION_COUNT_W-1:0]   count_r, count_nxt;
  logic [rssh_pkg::ZONE_TABLE_W-1:0]      ztab_r, ztab_nxt;
  logic                                   master_r, master_nxt;
  logic [rssh_pkg::SWITCH_W-1:0]          prev_main_r, prev_main_nxt;
  logic [rssh_pkg::SWITCH_W-1:0]          prev_offl_r, prev_offl_nxt;
  logic [rssh_pkg::SWITCH_W-1:0]          prev_offh_r, prev_offh_nxt;
  logic                                   accept;
  logic                                   active;
  logic [rssh_pkg::MASK_W-1:0]            on_hit, fall_hit, off_hit;
  logic [rssh_pkg::ZONE_ENTRY_W-1:0]      entry;
  logic                                   match;

  assign accept = in_valid && !in_stall;
  assign active = feat_r && in_job_active;

  always_comb begin
    feat_nxt  = feat_r;
    zones_nxt = zones_r;
    count_nxt = count_r;
    ztab_nxt  = ztab_r;
    if (cfg_we) begin
      unique case (cfg_index)
        rssh_pkg::CFG_FEATURE:    feat_nxt  = cfg_wdata[0];
        rssh_pkg::CFG_ZONES:      zones_nxt = cfg_wdata[0];
        rssh_pkg::CFG_COUNT:      count_nxt = cfg_wdata[rssh_pkg::SECTION_COUNT_W-1:0];
        rssh_pkg::CFG_ZONE_TABLE: ztab_nxt  = cfg_wdata[rssh_pkg::ZONE_TABLE_W-1:0];
      endcase
    end
  end

  always_comb begin
    master_nxt = master_r;
    if (active && (in_main_switch != prev_main_r)) begin
      if (in_main_switch[1]) begin
        master_nxt = 1'b1;
      end else if (in_main_switch[0]) begin
        master_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    on_hit   = '0;
    fall_hit = '0;
    off_hit  = '0;
    entry    = '0;
    match    = 1'b0;
    if (active) begin
      if (!zones_r) begin
        for (int s = 0; s < 8; s++) begin
          on_hit[s]     = in_on_low[s] && (5'(s) < count_r);
          on_hit[s+8]   = in_on_high[s] && (5'(s + 8) < count_r);
          fall_hit[s]   = prev_offl_r[s] && !in_off_low[s] && master_nxt;
          fall_hit[s+8] = prev_offh_r[s] && !in_off_high[s] && master_nxt;
          off_hit[s]    = in_off_low[s];
          off_hit[s+8]  = in_off_high[s];
        end
      end else begin
        for (int s = 0; s < MAX_SECTIONS; s++) begin
          for (int z = 0; z < NUM_ZONES; z++) begin
            entry = ztab_r[rssh_pkg::ZONE_ENTRY_W*z +: rssh_pkg::ZONE_ENTRY_W];
            match = (entry == 7'(s + 1));
            on_hit[s]   = on_hit[s] || (in_on_low[z] && match);
            fall_hit[s] = fall_hit[s] ||
                          (prev_offl_r[z] && !in_off_low[z] && master_nxt && match);
            off_hit[s]  = off_hit[s] || (in_off_low[z] && match);
          end
        end
      end
    end
  end

  always_comb begin
    prev_main_nxt = prev_main_r;
    prev_offl_nxt = prev_offl_r;
    prev_offh_nxt = prev_offh_r;
    if (active) begin
      prev_main_nxt = in_main_switch;
      prev_offl_nxt = in_off_low;
      if (!zones_r) begin
        prev_offh_nxt = in_off_high;
      end
    end
  end

  assign push             = accept;
  assign cmd.master_auto  = master_nxt;
  assign cmd.on_hit       = on_hit;
  assign cmd.fall_hit     = fall_hit;
  assign cmd.off_hit      = off_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feat_r      <= 1'b1;
      zones_r     <= 1'b0;
      count_r     <= 5'd16;
      ztab_r      <= '0;
      master_r    <= 1'b0;
      prev_main_r <= '0;
      prev_offl_r <= '0;
      prev_offh_r <= '0;
    end else begin
      feat_r  <= feat_nxt;
      zones_r <= zones_nxt;
      count_r <= count_nxt;
      ztab_r  <= ztab_nxt;
      if (accept) begin
        master_r    <= master_nxt;
        prev_main_r <= prev_main_nxt;
        prev_offl_r <= prev_offl_nxt;
        prev_offh_r <= prev_offh_nxt;
      end
    end
  end

  `RSSH_ASSERT_NEXT(a_disabled_holds, clk, rst_n, accept && !feat_r, $stable(master_r) && $stable(prev_main_r), "Disabled report changed master state")
endmodule

>>> design/rssh_queue.sv
// Two-entry command queue between the front end and the section state back end.
`include "remote_section_switch_handler_macros.svh"
module rssh_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rssh_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           q_valid,
  output logic           q_full,
  output rssh_pkg::cmd_t head_cmd
);
  rssh_pkg::cmd_t mem_r [rssh_pkg::QUEUE_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign q_valid  = (count_r != 2'd0);
  assign q_full   = (count_r == 2'(rssh_pkg::QUEUE_DEPTH));
  assign head_cmd = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `RSSH_ASSERT(a_count_bound, clk, rst_n, count_r <= 2'(rssh_pkg::QUEUE_DEPTH), "Queue count beyond depth")
  `RSSH_ASSERT_NEXT(a_push_grows, clk, rst_n, push && !pop, count_r == $past(count_r) + 2'd1, "Push did not grow queue")
endmodule

>>> design/rssh_back.sv
// Back end: per-section state array and the registered result beat.
`include "remote_section_switch_handler_macros.svh"
module rssh_back #(
  parameter int MAX_SECTIONS = rssh_pkg::MAX_SECTIONS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  rssh_pkg::cmd_t                head_cmd,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_master_auto,
  output logic [rssh_pkg::MASK_W-1:0]   out_on_mask,
  output logic [rssh_pkg::MASK_W-1:0]   out_off_mask
);
  rssh_pkg::sec_state_t              st_r   [MAX_SECTIONS];
  rssh_pkg::sec_state_t              st_nxt [MAX_SECTIONS];
  rssh_pkg::sec_state_t              after_on;
  logic                              out_valid_r;
  logic                              master_r;
  logic [rssh_pkg::MASK_W-1:0]       on_mask_r, on_mask_nxt;
  logic [rssh_pkg::MASK_W-1:0]       off_mask_r, off_mask_nxt;

  assign pop = q_valid && (!out_valid_r || !out_stall);

  always_comb begin
    on_mask_nxt  = '0;
    off_mask_nxt = '0;
    after_on     = rssh_pkg::ST_OFF;
    for (int s = 0; s < MAX_SECTIONS; s++) begin
      after_on = head_cmd.on_hit[s] ? rssh_pkg::ST_ON : st_r[s];
      if (head_cmd.off_hit[s]) begin
        st_nxt[s] = rssh_pkg::ST_OFF;
      end else if (head_cmd.fall_hit[s] && (after_on == rssh_pkg::ST_OFF)) begin
        st_nxt[s] = rssh_pkg::ST_AUTO;
      end else begin
        st_nxt[s] = after_on;
      end
      on_mask_nxt[s]  = (st_nxt[s] == rssh_pkg::ST_ON);
      off_mask_nxt[s] = (st_nxt[s] == rssh_pkg::ST_OFF);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int s = 0; s < MAX_SECTIONS; s++) begin
        st_r[s] <= rssh_pkg::ST_OFF;
      end
    end else begin
      if (pop) begin
        out_valid_r <= 1'b1;
        for (int s = 0; s < MAX_SECTIONS; s++) begin
          st_r[s] <= st_nxt[s];
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      master_r   <= head_cmd.master_auto;
      on_mask_r  <= on_mask_nxt;
      off_mask_r <= off_mask_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_master_auto = master_r;
  assign out_on_mask     = on_mask_r;
  assign out_off_mask    = off_mask_r;

  `RSSH_ASSERT(a_masks_disjoint, clk, rst_n, !out_valid_r || ((on_mask_r & off_mask_r) == '0), "Section both on and off")
endmodule

>>> design/remote_section_switch_handler.sv
// Top level of the remote section switch handler.
// A report is taken while the queue is not full; its result beat leaves the output register
// after the back end pops it. At the accepting edge the front end classifies the report into
// the two-entry command queue. When the output register is free, the back end applies the
// head command to the section states and loads the output register. The queue absorbs reports
// while the result side stalls. Throughput is one report per cycle unless stalled, set by the
// queue's single push and pop per cycle. Section states reset to off synchronously.
module remote_section_switch_handler #(
  parameter int MAX_SECTIONS = rssh_pkg::MAX_SECTIONS_DEF,
  parameter int NUM_ZONES    = rssh_pkg::NUM_ZONES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_job_active,
  input  logic [rssh_pkg::SWITCH_W-1:0]     in_main_switch,
  input  logic [rssh_pkg::SWITCH_W-1:0]     in_on_low,
  input  logic [rssh_pkg::SWITCH_W-1:0]     in_on_high,
  input  logic [rssh_pkg::SWITCH_W-1:0]     in_off_low,
  input  logic [rssh_pkg::SWITCH_W-1:0]     in_off_high,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_master_auto,
  output logic [rssh_pkg::MASK_W-1:0]       out_on_mask,
  output logic [rssh_pkg::MASK_W-1:0]       out_off_mask,
  input  logic                              cfg_we,
  input  logic [rssh_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rssh_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  logic           push;
  logic           pop;
  logic           q_valid;
  logic           q_full;
  rssh_pkg::cmd_t push_cmd;
  rssh_pkg::cmd_t head_cmd;

  assign in_stall = q_full;

  rssh_front #(
    .MAX_SECTIONS(MAX_SECTIONS),
    .NUM_ZONES   (NUM_ZONES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (q_full),
    .in_job_active (in_job_active),
    .in_main_switch(in_main_switch),
    .in_on_low     (in_on_low),
    .in_on_high    (in_on_high),
    .in_off_low    (in_off_low),
    .in_off_high   (in_off_high),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .push          (push),
    .cmd           (push_cmd)
  );

  rssh_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .q_valid (q_valid),
    .q_full  (q_full),
    .head_cmd(head_cmd)
  );

  rssh_back #(
    .MAX_SECTIONS(MAX_SECTIONS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .head_cmd       (head_cmd),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_master_auto(out_master_auto),
    .out_on_mask    (out_on_mask),
    .out_off_mask   (out_off_mask)
  );
endmodule

>>> tb/remote_section_switch_handler_tb.sv
// Self-checking testbench for the remote section switch handler.
`timescale 1ns / 100ps

module remote_section_switch_handler_tb;
  localparam int NSEC        = rssh_pkg::MAX_SECTIONS_DEF;
  localparam int CYCLE_LIMIT = 300000;

  typedef logic [rssh_pkg::CFG_DATA_W-1:0] cfg_word_t;

  typedef struct packed {
    logic                          job;
    logic [rssh_pkg::SWITCH_W-1:0] main_sw;
    logic [rssh_pkg::SWITCH_W-1:0] on_lo;
    logic [rssh_pkg::SWITCH_W-1:0] on_hi;
    logic [rssh_pkg::SWITCH_W-1:0] off_lo;
    logic [rssh_pkg::SWITCH_W-1:0] off_hi;
  } report_t;

  typedef struct packed {
    logic                        master_auto;
    logic [rssh_pkg::MASK_W-1:0] on_mask;
    logic [rssh_pkg::MASK_W-1:0] off_mask;
  } masks_t;

  class section_state_tracker;
    logic                                 enabled;
    logic                                 zone_mode;
    logic [rssh_pkg::SECTION_COUNT_W-1:0] sec_count;
    logic [rssh_pkg::ZONE_TABLE_W-1:0]    zone_map;
    logic                                 master_auto;
    logic [rssh_pkg::SWITCH_W-1:0]        last_main;
    logic [rssh_pkg::SWITCH_W-1:0]        last_off_lo;
    logic [rssh_pkg::SWITCH_W-1:0]        last_off_hi;
    rssh_pkg::sec_state_t                 sec[NSEC];
    masks_t                               expected_masks[$];
    int                                   mismatches;

    function new();
      enabled     = 1'b1;
      zone_mode   = 1'b0;
      sec_count   = 5'd16;
      zone_map    = '0;
      master_auto = 1'b0;
      last_main   = '0;
      last_off_lo = '0;
      last_off_hi = '0;
      foreach (sec[s]) sec[s] = rssh_pkg::ST_OFF;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [rssh_pkg::CFG_INDEX_W-1:0] idx, cfg_word_t data);
      case (idx)
        rssh_pkg::CFG_FEATURE:    enabled = data[0];
        rssh_pkg::CFG_ZONES:      zone_mode = data[0];
        rssh_pkg::CFG_COUNT:      sec_count = data[rssh_pkg::SECTION_COUNT_W-1:0];
        rssh_pkg::CFG_ZONE_TABLE: zone_map = data[rssh_pkg::ZONE_TABLE_W-1:0];
        default: ;
      endcase
    endfunction

    function int zone_section(int z);
      logic [rssh_pkg::ZONE_ENTRY_W-1:0] e;
      e = zone_map[rssh_pkg::ZONE_ENTRY_W*z +: rssh_pkg::ZONE_ENTRY_W];
      if (e == 0 || int'(e) - 1 >= NSEC) return -1;
      return int'(e) - 1;
    endfunction

    function void set_section(int s, rssh_pkg::sec_state_t v);
      if (s >= 0 && s < NSEC) sec[s] = v;
    endfunction

    function void apply_off(int base, logic [rssh_pkg::SWITCH_W-1:0] cur,
                            logic [rssh_pkg::SWITCH_W-1:0] prev);
      if (cur != prev && master_auto) begin
        for (int s = 0; s < 8; s++) begin
          if (prev[s] && !cur[s] && sec[base + s] == rssh_pkg::ST_OFF)
            sec[base + s] = rssh_pkg::ST_AUTO;
        end
      end
      for (int s = 0; s < 8; s++) begin
        if (cur[s]) sec[base + s] = rssh_pkg::ST_OFF;
      end
    endfunction

    function void take_report(report_t r);
      masks_t res;
      int t;
      if (enabled && r.job) begin
        if (r.main_sw != last_main) begin
          if (r.main_sw[0]) master_auto = 1'b0;
          if (r.main_sw[1]) master_auto = 1'b1;
          last_main = r.main_sw;
        end
        if (!zone_mode) begin
          for (int s = 0; s < 8; s++) begin
            if (r.on_lo[s] && s < int'(sec_count)) set_section(s, rssh_pkg::ST_ON);
            if (r.on_hi[s] && s + 8 < int'(sec_count)) set_section(s + 8, rssh_pkg::ST_ON);
          end
          apply_off(0, r.off_lo, last_off_lo);
          apply_off(8, r.off_hi, last_off_hi);
          last_off_lo = r.off_lo;
          last_off_hi = r.off_hi;
        end else begin
          for (int s = 0; s < 8; s++) begin
            if (r.on_lo[s]) set_section(zone_section(s), rssh_pkg::ST_ON);
          end
          if (r.off_lo != last_off_lo && master_auto) begin
            for (int s = 0; s < 8; s++) begin
              t = zone_section(s);
              if (t >= 0 && last_off_lo[s] && !r.off_lo[s] && sec[t] == rssh_pkg::ST_OFF)
                sec[t] = rssh_pkg::ST_AUTO;
            end
          end
          last_off_lo = r.off_lo;
          for (int s = 0; s < 8; s++) begin
            if (r.off_lo[s]) set_section(zone_section(s), rssh_pkg::ST_OFF);
          end
        end
      end
      res.master_auto = master_auto;
      res.on_mask     = '0;
      res.off_mask    = '0;
      for (int s = 0; s < NSEC; s++) begin
        if (sec[s] == rssh_pkg::ST_ON) res.on_mask[s] = 1'b1;
        else if (sec[s] == rssh_pkg::ST_OFF) res.off_mask[s] = 1'b1;
      end
      expected_masks.push_back(res);
    endfunction

    function void compare_result(logic ma, logic [rssh_pkg::MASK_W-1:0] onm,
                                 logic [rssh_pkg::MASK_W-1:0] offm);
      masks_t want;
      if (expected_masks.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing expected: master_auto %0b on %h off %h",
                 $time, ma, onm, offm);
        return;
      end
      want = expected_masks.pop_front();
      if (ma !== want.master_auto) begin
        mismatches++;
        $display("%0t: master_auto expected %0b actual %0b", $time, want.master_auto, ma);
      end
      if (onm !== want.on_mask) begin
        mismatches++;
        $display("%0t: on_mask expected %h actual %h", $time, want.on_mask, onm);
      end
      if (offm !== want.off_mask) begin
        mismatches++;
        $display("%0t: off_mask expected %h actual %h", $time, want.off_mask, offm);
      end
    endfunction

    function int pending();
      return expected_masks.size();
    endfunction
  endclass

  logic                             clk;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_stall;
  logic                             in_job_active;
  logic [rssh_pkg::SWITCH_W-1:0]    in_main_switch;
  logic [rssh_pkg::SWITCH_W-1:0]    in_on_low;
  logic [rssh_pkg::SWITCH_W-1:0]    in_on_high;
  logic [rssh_pkg::SWITCH_W-1:0]    in_off_low;
  logic [rssh_pkg::SWITCH_W-1:0]    in_off_high;
  logic                             out_valid;
  logic                             out_stall;
  logic                             out_master_auto;
  logic [rssh_pkg::MASK_W-1:0]      out_on_mask;
  logic [rssh_pkg::MASK_W-1:0]      out_off_mask;
  logic                             cfg_we;
  logic [rssh_pkg::CFG_INDEX_W-1:0] cfg_index;
  cfg_word_t                        cfg_wdata;

  section_state_tracker          tracker = new();
  int                            cycle_count = 0;
  bit                            sender_gaps;
  bit                            receiver_gaps;
  logic [rssh_pkg::SWITCH_W-1:0] gen_off_lo;
  logic [rssh_pkg::SWITCH_W-1:0] gen_off_hi;

  remote_section_switch_handler i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_job_active   (in_job_active),
    .in_main_switch  (in_main_switch),
    .in_on_low       (in_on_low),
    .in_on_high      (in_on_high),
    .in_off_low      (in_off_low),
    .in_off_high     (in_off_high),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_master_auto (out_master_auto),
    .out_on_mask     (out_on_mask),
    .out_off_mask    (out_off_mask),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && !out_stall)
      tracker.compare_result(out_master_auto, out_on_mask, out_off_mask);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int hold;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      hold = receiver_gaps ? $urandom_range(0, 10) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid || out_stall);
    end
  end

  function automatic report_t rpt(logic job, logic [7:0] main_sw, logic [7:0] on_lo,
                                  logic [7:0] on_hi, logic [7:0] off_lo, logic [7:0] off_hi);
    report_t r;
    r = '{job, main_sw, on_lo, on_hi, off_lo, off_hi};
    return r;
  endfunction

  // Leaves in_valid high after the beat so that back-to-back beats need no toggle.
  task automatic send_report(input report_t r);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_job_active  <= r.job;
    in_main_switch <= r.main_sw;
    in_on_low      <= r.on_lo;
    in_on_high     <= r.on_hi;
    in_off_low     <= r.off_lo;
    in_off_high    <= r.off_hi;
    do @(posedge clk); while (in_stall);
    tracker.take_report(r);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_block(input logic en, input logic zones, input logic [4:0] cnt,
                               input logic [rssh_pkg::ZONE_TABLE_W-1:0] zmap);
    cfg_word_t                        vals[4];
    logic [rssh_pkg::CFG_INDEX_W-1:0] idx[4];
    vals = '{cfg_word_t'(en), cfg_word_t'(zones), cfg_word_t'(cnt), cfg_word_t'(zmap)};
    idx  = '{rssh_pkg::CFG_FEATURE, rssh_pkg::CFG_ZONES, rssh_pkg::CFG_COUNT,
             rssh_pkg::CFG_ZONE_TABLE};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= vals[i];
      tracker.write_reg(idx[i], vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] random_on();
    case ($urandom_range(0, 3))
      0, 1:    return 8'h00;
      2:       return 8'h01 << $urandom_range(0, 7);
      default: return 8'($urandom);
    endcase
  endfunction

  // Off bytes evolve from their last value so that held and falling bits are common.
  function automatic logic [7:0] evolve_off(logic [7:0] prev);
    case ($urandom_range(0, 5))
      0:       return prev;
      1, 2:    return prev & 8'($urandom);
      3:       return prev | (8'h01 << $urandom_range(0, 7));
      4:       return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [rssh_pkg::ZONE_TABLE_W-1:0] random_zone_map();
    logic [rssh_pkg::ZONE_TABLE_W-1:0] m;
    logic [rssh_pkg::ZONE_ENTRY_W-1:0] e;
    m = '0;
    for (int z = 0; z < 8; z++) begin
      case ($urandom_range(0, 3))
        0:       e = '0;
        1:       e = 7'($urandom_range(1, 16));
        2:       e = 7'($urandom_range(17, 64));
        default: e = 7'($urandom_range(65, 127));
      endcase
      m[rssh_pkg::ZONE_ENTRY_W*z +: rssh_pkg::ZONE_ENTRY_W] = e;
    end
    return m;
  endfunction

  task automatic run_random(input int n, input bit gaps_in, input bit gaps_out);
    report_t r;
    sender_gaps   = gaps_in;
    receiver_gaps = gaps_out;
    for (int i = 0; i < n; i++) begin
      gen_off_lo = evolve_off(gen_off_lo);
      gen_off_hi = evolve_off(gen_off_hi);
      r.job      = ($urandom_range(0, 7) != 0);
      r.main_sw  = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
      r.on_lo    = random_on();
      r.on_hi    = random_on();
      r.off_lo   = gen_off_lo;
      r.off_hi   = gen_off_hi;
      send_report(r);
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_job_active  <= 1'b0;
    in_main_switch <= '0;
    in_on_low      <= '0;
    in_on_high     <= '0;
    in_off_low     <= '0;
    in_off_high    <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= rssh_pkg::CFG_FEATURE;
    cfg_wdata      <= '0;
    sender_gaps    = 1'b0;
    receiver_gaps  = 1'b0;
    gen_off_lo     = '0;
    gen_off_hi     = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration: sections, all sixteen present.
    send_report(rpt(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00));
    send_report(rpt(1'b1, 8'h02, 8'hFF, 8'hFF, 8'h00, 8'h00));
    send_report(rpt(1'b1, 8'h02, 8'h00, 8'h00, 8'hFF, 8'hFF));
    send_report(rpt(1'b1, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(rpt(1'b1, 8'h01, 8'h55, 8'hAA, 8'hFF, 8'hFF));
    send_report(rpt(1'b1, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(rpt(1'b1, 8'h03, 8'h00, 8'h00, 8'hAA, 8'h55));
    send_report(rpt(1'b1, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(rpt(1'b1, 8'hFC, 8'h0F, 8'hF0, 8'h00, 8'h00));
    send_report(rpt(1'b0, 8'h01, 8'h00, 8'h00, 8'hFF, 8'hFF));
    send_report(rpt(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_report(rpt(1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    run_random(260, 1'b0, 1'b0);
    run_random(0, 1'b1, 1'b1);

    quiesce();
    program_block(1'b1, 1'b0, 5'd1, '0);
    send_report(rpt(1'b1, 8'h02, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_report(rpt(1'b1, 8'h02, 8'hFF, 8'hFF, 8'h00, 8'h00));
    run_random(110, 1'b1, 1'b1);

    quiesce();
    program_block(1'b1, 1'b0, 5'($urandom_range(2, 15)), '1);
    run_random(110, 1'b1, 1'b0);

    // Zone table: section 0, section 63, unused, two oversized, a duplicate, 15 and 16.
    quiesce();
    program_block(1'b1, 1'b1, 5'd16,
                  {7'd17, 7'd16, 7'd1, 7'd127, 7'd65, 7'd0, 7'd64, 7'd1});
    send_report(rpt(1'b1, 8'h02, 8'hFF, 8'hFF, 8'h00, 8'hFF));
    send_report(rpt(1'b1, 8'h02, 8'h00, 8'h00, 8'hFF, 8'h00));
    send_report(rpt(1'b1, 8'h02, 8'h00, 8'hFF, 8'h00, 8'hFF));
    send_report(rpt(1'b1, 8'h01, 8'h00, 8'h00, 8'hFF, 8'h00));
    send_report(rpt(1'b1, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00));
    run_random(220, 1'b0, 1'b1);

    quiesce();
    program_block(1'b1, 1'b1, 5'($urandom_range(1, 16)), random_zone_map());
    run_random(150, 1'b1, 1'b1);

    quiesce();
    program_block(1'b1, 1'b1, 5'd16, '1);
    run_random(40, 1'b1, 1'b1);

    quiesce();
    program_block(1'b0, 1'b0, 5'd16, random_zone_map());
    run_random(60, 1'b1, 1'b1);

    quiesce();
    program_block(1'b1, 1'b0, 5'd16, '0);
    run_random(90, 1'b1, 1'b1);
    quiesce();
    run_random(90, 1'b0, 1'b0);

    quiesce();
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
